### rtl/aiu_echo_pkg.sv
// Package for the ARP, ICMP and UDP echo responder: constants, types and microcode table.
package aiu_echo_pkg;

   localparam int ICMP_DATA_BYTES = 32;
   localparam int ICMP_TOTAL      = 42 + ICMP_DATA_BYTES;
   localparam int ARP_TOTAL       = 42;
   localparam int UDP_TOTAL       = 42;
   localparam int STORE_DEPTH     = ICMP_TOTAL;
   localparam int ADDR_W          = $clog2(STORE_DEPTH);

   localparam int COUNT_W   = 7;
   localparam int COUNT_MAX = 127;

   localparam int MIN_ETH = 14;
   localparam int MIN_IP  = 24;

   localparam int POS_ETYPE_HI  = 12;
   localparam int POS_ETYPE_LO  = 13;
   localparam int POS_PROTO     = 23;
   localparam int POS_ICMP_TYPE = 34;
   localparam int POS_TIP       = 38;

   localparam int CSUM_FIRST = 38;
   localparam int CSUM_WORDS = (ICMP_TOTAL - CSUM_FIRST + 1) / 2;
   localparam int CSUM_W     = 16 + $clog2(CSUM_WORDS + 1);

   localparam int ICMP_WORDS = (ICMP_TOTAL + 1) / 2;
   localparam int ARP_WORDS  = (ARP_TOTAL + 1) / 2;
   localparam int UDP_WORDS  = (UDP_TOTAL + 1) / 2;

   localparam int ICMP_BASE   = 9;
   localparam int ARP_BASE    = ICMP_BASE + ICMP_WORDS;
   localparam int UDP_BASE    = ARP_BASE + ARP_WORDS;
   localparam int DONE_ADDR   = UDP_BASE + UDP_WORDS;
   localparam int UCODE_DEPTH = DONE_ADDR + 1;
   localparam int PC_W        = $clog2(UCODE_DEPTH);

   localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
   localparam logic [15:0] ETYPE_ARP     = 16'h0806;
   localparam logic [7:0]  IP_PROT_ICMP  = 8'd1;
   localparam logic [7:0]  IP_PROT_UDP   = 8'd17;
   localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;

   localparam int          CSR_W       = 2;
   localparam logic [1:0]  CSR_OWN_IP  = 2'd0;
   localparam logic [1:0]  CSR_OWN_MAC = 2'd1;
   localparam logic [1:0]  CSR_UDP_EN  = 2'd2;

   localparam logic [31:0] OWN_IP_RESET  = 32'hC0A852A8;
   localparam logic [47:0] OWN_MAC_RESET = 48'h000C29FBC66B;

   localparam logic [1:0] KIND_ARP  = 2'd0;
   localparam logic [1:0] KIND_ICMP = 2'd1;
   localparam logic [1:0] KIND_UDP  = 2'd2;

   typedef enum logic [1:0] {
      OP_BRANCH = 2'd0,
      OP_EMIT   = 2'd1,
      OP_STOP   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      COND_SHORT    = 3'd0,
      COND_NOT_ARP  = 3'd1,
      COND_ARP_BAD  = 3'd2,
      COND_NOT_IP   = 3'd3,
      COND_NOT_UDP  = 3'd4,
      COND_UDP_OFF  = 3'd5,
      COND_NOT_ICMP = 3'd6,
      COND_ALWAYS   = 3'd7
   } cond_type;

   typedef enum logic [2:0] {
      SEL_MEM     = 3'd0,
      SEL_MAC     = 3'd1,
      SEL_CONST   = 3'd2,
      SEL_CSUM_HI = 3'd3,
      SEL_CSUM_LO = 3'd4
   } sel_type;

   typedef struct packed {
      sel_type    sel;
      logic [7:0] arg;
   } src_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      src_type         hi;
      src_type         lo;
      logic [1:0]      kind;
      logic            last;
   } ucode_type;

   function automatic src_type byte_src(input logic [1:0] k, input int j);
      src_type s;
      int      m;
      m     = j;
      s.sel = SEL_MEM;
      s.arg = 8'd0;
      if (k == KIND_ARP) begin
         if (j < 6) begin
            m = j + 6;
         end else if (j < 12) begin
            s.sel = SEL_MAC;
            m     = j - 6;
         end else if (j == 18) begin
            s.sel = SEL_CONST;
            m     = 6;
         end else if (j == 19) begin
            s.sel = SEL_CONST;
            m     = 4;
         end else if (j == 20) begin
            s.sel = SEL_CONST;
            m     = 0;
         end else if (j == 21) begin
            s.sel = SEL_CONST;
            m     = 2;
         end else if (j >= 22 && j < 28) begin
            s.sel = SEL_MAC;
            m     = j - 22;
         end else if (j >= 28 && j < 32) begin
            m = j + 10;
         end else if (j >= 32 && j < 42) begin
            m = j - 10;
         end
      end else begin
         if (j < 6) begin
            m = j + 6;
         end else if (j < 12) begin
            m = j - 6;
         end else if (j >= 26 && j < 30) begin
            m = j + 4;
         end else if (j >= 30 && j < 34) begin
            m = j - 4;
         end else if (k == KIND_UDP) begin
            if (j == 34 || j == 35) begin
               m = j + 2;
            end else if (j == 36 || j == 37) begin
               m = j - 2;
            end
         end else begin
            if (j == 34 || j == 35 || j >= ICMP_TOTAL) begin
               s.sel = SEL_CONST;
               m     = 0;
            end else if (j == 36) begin
               s.sel = SEL_CSUM_HI;
            end else if (j == 37) begin
               s.sel = SEL_CSUM_LO;
            end
         end
      end
      s.arg = 8'(m);
      return s;
   endfunction

   function automatic ucode_type ucode(input logic [PC_W-1:0] addr);
      ucode_type cw;
      int        a;
      int        w;
      a         = int'(addr);
      w         = 0;
      cw.op     = OP_STOP;
      cw.cond   = COND_ALWAYS;
      cw.target = PC_W'(DONE_ADDR);
      cw.hi     = '{sel: SEL_CONST, arg: 8'd0};
      cw.lo     = '{sel: SEL_CONST, arg: 8'd0};
      cw.kind   = KIND_ARP;
      cw.last   = 1'b0;
      if (a < ICMP_BASE) begin
         cw.op = OP_BRANCH;
         case (a)
            0: cw.cond = COND_SHORT;
            1: begin
               cw.cond   = COND_NOT_ARP;
               cw.target = PC_W'(4);
            end
            2: cw.cond = COND_ARP_BAD;
            3: cw.target = PC_W'(ARP_BASE);
            4: cw.cond = COND_NOT_IP;
            5: begin
               cw.cond   = COND_NOT_UDP;
               cw.target = PC_W'(8);
            end
            6: cw.cond = COND_UDP_OFF;
            7: cw.target = PC_W'(UDP_BASE);
            default: cw.cond = COND_NOT_ICMP;
         endcase
      end else if (a < ARP_BASE) begin
         w       = a - ICMP_BASE;
         cw.op   = OP_EMIT;
         cw.kind = KIND_ICMP;
         cw.hi   = byte_src(KIND_ICMP, 2 * w);
         cw.lo   = byte_src(KIND_ICMP, 2 * w + 1);
         cw.last = (w == ICMP_WORDS - 1);
      end else if (a < UDP_BASE) begin
         w       = a - ARP_BASE;
         cw.op   = OP_EMIT;
         cw.kind = KIND_ARP;
         cw.hi   = byte_src(KIND_ARP, 2 * w);
         cw.lo   = byte_src(KIND_ARP, 2 * w + 1);
         cw.last = (w == ARP_WORDS - 1);
      end else if (a < DONE_ADDR) begin
         w       = a - UDP_BASE;
         cw.op   = OP_EMIT;
         cw.kind = KIND_UDP;
         cw.hi   = byte_src(KIND_UDP, 2 * w);
         cw.lo   = byte_src(KIND_UDP, 2 * w + 1);
         cw.last = (w == UDP_WORDS - 1);
      end
      return cw;
   endfunction

endpackage

### rtl/arp_icmp_udp_echo_responder.sv
// ARP, ICMP echo and UDP header echo responder with a microcoded reply sequencer.
//
// Frame bytes enter on the req_ channel, one transaction per byte, starting at the
// destination MAC; req_rx_last marks the final byte. Bytes are taken one per cycle while
// the sequencer is idle and stored in a frame buffer while an ICMP checksum sum builds
// up on the fly. When the final byte is taken, a microcode program in a constant table
// runs: a few branch steps classify the frame, then one step per reply word reads
// two buffer bytes through the buffer's two read ports. Reply words leave on the rsp_
// channel, one per cycle while rsp_stall is low, after passing the buffer read
// registers and the output registers; an ARP or UDP reply is 21 words, an ICMP echo
// reply 37 words. req_stall stays high from the final byte until the last reply
// word has been issued into the output pipeline, or until the program stops on a
// frame that gets no reply.
// When rsp_stall is high with a word waiting, the whole sequencer and buffer read
// pipeline hold. Reset clears the sequencer, the byte counter, the output valid
// and sets the configuration registers to their defaults. The csr_ port takes one
// register write per cycle and is always ready.
module arp_icmp_udp_echo_responder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           req_rx_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [15:0]                    rsp_tx_word,
   output logic [1:0]                     rsp_reply_kind,
   output logic                           rsp_tx_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [aiu_echo_pkg::CSR_W-1:0] csr_index,
   input  logic [47:0]                    csr_wdata
);

   localparam int CW = aiu_echo_pkg::COUNT_W;
   localparam int AW = aiu_echo_pkg::ADDR_W;
   localparam int PW = aiu_echo_pkg::PC_W;
   localparam int SW = aiu_echo_pkg::CSUM_W;

   logic [31:0] own_ip_ff, own_ip_in;
   logic [47:0] own_mac_ff, own_mac_in;
   logic        udp_en_ff, udp_en_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] cnt_inc;
   logic [15:0]   etype_ff, etype_in;
   logic [7:0]    proto_ff, proto_in;
   logic [7:0]    icmp_type_ff, icmp_type_in;
   logic [31:0]   tip_ff, tip_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [SW-1:0] sum_add;

   logic [7:0] store_mem [aiu_echo_pkg::STORE_DEPTH];
   logic [7:0] rd_hi_ff;
   logic [7:0] rd_lo_ff;

   logic                      busy_ff, busy_in;
   logic [PW-1:0]             pc_ff, pc_in;
   aiu_echo_pkg::ucode_type   cw;
   logic                      cond_true;

   logic                      b_valid_ff, b_valid_in;
   aiu_echo_pkg::ucode_type   b_ctrl_ff, b_ctrl_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_tx_word_ff, rsp_tx_word_in;
   logic [1:0]  rsp_reply_kind_ff, rsp_reply_kind_in;
   logic        rsp_tx_last_ff, rsp_tx_last_in;

   logic        req_accept;
   logic        adv;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] csum;

   function automatic logic [7:0] pick(input aiu_echo_pkg::src_type s, input logic [7:0] rd,
                                       input logic [47:0] mac, input logic [15:0] ck);
      logic [7:0] v;
      v = 8'd0;
      case (s.sel)
         aiu_echo_pkg::SEL_MEM:     v = rd;
         aiu_echo_pkg::SEL_CONST:   v = s.arg;
         aiu_echo_pkg::SEL_CSUM_HI: v = ck[15:8];
         aiu_echo_pkg::SEL_CSUM_LO: v = ck[7:0];
         aiu_echo_pkg::SEL_MAC: begin
            case (s.arg[2:0])
               3'd0:    v = mac[47:40];
               3'd1:    v = mac[39:32];
               3'd2:    v = mac[31:24];
               3'd3:    v = mac[23:16];
               3'd4:    v = mac[15:8];
               3'd5:    v = mac[7:0];
               default: v = 8'd0;
            endcase
         end
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign csr_ready  = 1'b1;
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign cw         = aiu_echo_pkg::ucode(pc_ff);

   always_comb begin
      own_ip_in  = own_ip_ff;
      own_mac_in = own_mac_ff;
      udp_en_in  = udp_en_ff;
      if (csr_valid) begin
         case (csr_index)
            aiu_echo_pkg::CSR_OWN_IP:  own_ip_in  = csr_wdata[31:0];
            aiu_echo_pkg::CSR_OWN_MAC: own_mac_in = csr_wdata;
            aiu_echo_pkg::CSR_UDP_EN:  udp_en_in  = csr_wdata[0];
            default:                   own_ip_in  = own_ip_ff;
         endcase
      end
   end

   always_comb begin
      cnt_inc      = (cnt_ff < CW'(aiu_echo_pkg::COUNT_MAX)) ? cnt_ff + CW'(1) : cnt_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      etype_in     = etype_ff;
      proto_in     = proto_ff;
      icmp_type_in = icmp_type_ff;
      tip_in       = tip_ff;
      sum_add      = '0;
      if (cnt_ff >= CW'(aiu_echo_pkg::CSUM_FIRST) && cnt_ff < CW'(aiu_echo_pkg::ICMP_TOTAL)) begin
         sum_add = cnt_ff[0] ? SW'({8'd0, req_rx_byte}) : SW'({req_rx_byte, 8'd0});
      end
      sum_in = sum_ff;
      if (req_accept) begin
         sum_in = ((cnt_ff == '0) ? '0 : sum_ff) + sum_add;
         cnt_in = req_rx_last ? '0 : cnt_inc;
         if (req_rx_last) begin
            len_in = cnt_inc;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_ETYPE_HI)) begin
            etype_in[15:8] = req_rx_byte;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_ETYPE_LO)) begin
            etype_in[7:0] = req_rx_byte;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_PROTO)) begin
            proto_in = req_rx_byte;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_ICMP_TYPE)) begin
            icmp_type_in = req_rx_byte;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_TIP)) begin
            tip_in[31:24] = req_rx_byte;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_TIP + 1)) begin
            tip_in[23:16] = req_rx_byte;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_TIP + 2)) begin
            tip_in[15:8] = req_rx_byte;
         end
         if (cnt_ff == CW'(aiu_echo_pkg::POS_TIP + 3)) begin
            tip_in[7:0] = req_rx_byte;
         end
      end
   end

   always_comb begin
      case (cw.cond)
         aiu_echo_pkg::COND_SHORT:
            cond_true = len_ff < CW'(aiu_echo_pkg::MIN_ETH);
         aiu_echo_pkg::COND_NOT_ARP:
            cond_true = etype_ff != aiu_echo_pkg::ETYPE_ARP;
         aiu_echo_pkg::COND_ARP_BAD:
            cond_true = len_ff < CW'(aiu_echo_pkg::ARP_TOTAL) || tip_ff != own_ip_ff;
         aiu_echo_pkg::COND_NOT_IP:
            cond_true = etype_ff != aiu_echo_pkg::ETYPE_IPV4 ||
                        len_ff < CW'(aiu_echo_pkg::MIN_IP);
         aiu_echo_pkg::COND_NOT_UDP:
            cond_true = proto_ff != aiu_echo_pkg::IP_PROT_UDP;
         aiu_echo_pkg::COND_UDP_OFF:
            cond_true = len_ff < CW'(aiu_echo_pkg::UDP_TOTAL) || !udp_en_ff;
         aiu_echo_pkg::COND_NOT_ICMP:
            cond_true = proto_ff != aiu_echo_pkg::IP_PROT_ICMP ||
                        len_ff < CW'(aiu_echo_pkg::ICMP_TOTAL) ||
                        icmp_type_ff != aiu_echo_pkg::ICMP_ECHO_REQ;
         aiu_echo_pkg::COND_ALWAYS:
            cond_true = 1'b1;
         default:
            cond_true = 1'b0;
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      pc_in      = pc_ff;
      b_valid_in = b_valid_ff;
      b_ctrl_in  = b_ctrl_ff;
      if (req_accept && req_rx_last) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end
      if (adv) begin
         b_valid_in = busy_ff && cw.op == aiu_echo_pkg::OP_EMIT;
         b_ctrl_in  = cw;
         if (busy_ff) begin
            case (cw.op)
               aiu_echo_pkg::OP_BRANCH: pc_in = cond_true ? cw.target : pc_ff + PW'(1);
               aiu_echo_pkg::OP_EMIT: begin
                  pc_in = pc_ff + PW'(1);
                  if (cw.last) begin
                     busy_in = 1'b0;
                  end
               end
               default: busy_in = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      fold1 = 17'(sum_ff[15:0]) + 17'(sum_ff[SW-1:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
      csum  = ~fold2;
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_tx_word_in    = rsp_tx_word_ff;
      rsp_reply_kind_in = rsp_reply_kind_ff;
      rsp_tx_last_in    = rsp_tx_last_ff;
      if (adv) begin
         rsp_valid_in      = b_valid_ff;
         rsp_tx_word_in    = {pick(b_ctrl_ff.hi, rd_hi_ff, own_mac_ff, csum),
                              pick(b_ctrl_ff.lo, rd_lo_ff, own_mac_ff, csum)};
         rsp_reply_kind_in = b_ctrl_ff.kind;
         rsp_tx_last_in    = b_ctrl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && cnt_ff < CW'(aiu_echo_pkg::STORE_DEPTH)) begin
         store_mem[cnt_ff[AW-1:0]] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_hi_ff <= store_mem[cw.hi.arg[AW-1:0]];
         rd_lo_ff <= store_mem[cw.lo.arg[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff    <= aiu_echo_pkg::OWN_IP_RESET;
         own_mac_ff   <= aiu_echo_pkg::OWN_MAC_RESET;
         udp_en_ff    <= 1'b1;
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         own_ip_ff    <= own_ip_in;
         own_mac_ff   <= own_mac_in;
         udp_en_ff    <= udp_en_in;
         cnt_ff       <= cnt_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff            <= len_in;
      etype_ff          <= etype_in;
      proto_ff          <= proto_in;
      icmp_type_ff      <= icmp_type_in;
      tip_ff            <= tip_in;
      sum_ff            <= sum_in;
      b_ctrl_ff         <= b_ctrl_in;
      rsp_tx_word_ff    <= rsp_tx_word_in;
      rsp_reply_kind_ff <= rsp_reply_kind_in;
      rsp_tx_last_ff    <= rsp_tx_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_word    = rsp_tx_word_ff;
   assign rsp_reply_kind = rsp_reply_kind_ff;
   assign rsp_tx_last    = rsp_tx_last_ff;

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_rx_last |=> busy_ff && pc_ff == '0)
      else $error("sequencer did not start at the end of a frame");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> int'(pc_ff) < aiu_echo_pkg::UCODE_DEPTH)
      else $error("microcode step counter out of range");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && adv && cw.op == aiu_echo_pkg::OP_EMIT && cw.last |=> !busy_ff)
      else $error("sequencer still busy after the last reply word");

   a_kind_steady: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && rsp_valid_ff && !rsp_tx_last_ff |-> b_ctrl_ff.kind == rsp_reply_kind_ff)
      else $error("reply kind changed within one reply");

endmodule
